/* rtl/core/frp_pkg.sv */
`timescale 1ns / 1ps

package frp_pkg;

  // frame delimiters and type bytes
  localparam logic [7:0] SYNC_FIRST      = 8'h41;  // 'A'
  localparam logic [7:0] SYNC_SECOND     = 8'h71;  // 'q'
  localparam logic [7:0] TYPE_COMMAND    = 8'h43;  // 'C'
  localparam logic [7:0] TYPE_TELEM      = 8'h54;  // 'T'
  localparam logic [7:0] PARAM_COUNT_MIN = 8'd3;

  // result kinds
  localparam logic [2:0] KIND_ACK       = 3'd0;
  localparam logic [2:0] KIND_NACK      = 3'd1;
  localparam logic [2:0] KIND_PARAM     = 3'd2;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
  localparam logic [2:0] KIND_TELEM_WORD = 3'd4;
  localparam logic [2:0] KIND_TELEM_END = 3'd5;

  // configuration register map
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_ACK_CODE   = 2'd0;
  localparam logic [1:0] REG_NACK_CODE  = 2'd1;
  localparam logic [1:0] REG_PARAM_CODE = 2'd2;

  typedef struct packed {
    logic [7:0] ack_code;
    logic [7:0] nack_code;
    logic [7:0] param_reply_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  command_code;
    logic [15:0] sequence_id;
    logic [15:0] param_id;
    logic        has_param;
    logic [7:0]  row_index;
    logic [7:0]  col_index;
    logic [31:0] word_bits;
    logic        checksum_ok;
    logic        last;
  } result_t;

endpackage

/* rtl/core/frp_cfg_regs.sv */
`timescale 1ns / 1ps

module frp_cfg_regs
  import frp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_code         <= 8'd0;
      cfg_q.nack_code        <= 8'd1;
      cfg_q.param_reply_code <= 8'd2;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACK_CODE:   cfg_q.ack_code         <= pwdata[7:0];
        REG_NACK_CODE:  cfg_q.nack_code        <= pwdata[7:0];
        REG_PARAM_CODE: cfg_q.param_reply_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_ACK_CODE:   prdata = {24'd0, cfg_q.ack_code};
      REG_NACK_CODE:  prdata = {24'd0, cfg_q.nack_code};
      REG_PARAM_CODE: prdata = {24'd0, cfg_q.param_reply_code};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/framed_reply_parser_core.sv */
`timescale 1ns / 1ps

// Framed reply parser: takes one received byte per beat, hunts for the sync
// pair 'A','q', then decodes a command reply frame ('C') or a telemetry frame
// ('T'), checking the two running 8-bit Fletcher sums carried at the frame
// end. A command reply gives one result beat, classed as ack, nack, param
// reply or unknown against the three code registers, and only when both
// checksum bytes match. A telemetry frame gives one beat per 32-bit raw word
// as it completes, then an end beat with checksum_ok. Every byte is handled
// in the cycle it is accepted by the parser state register, so one byte is
// taken per clock while in_stall_o is low; a result is registered into the
// output register, or into the skid entry when the output stalls, and this
// two-entry stage keeps input flowing while the downstream side stalls, so
// the input only stalls when both entries hold results. The code registers
// should be written while the parser is idle.
module framed_reply_parser_core
  import frp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // byte input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            kind_o,
  output logic [7:0]            command_code_o,
  output logic [15:0]           sequence_id_o,
  output logic [15:0]           param_id_o,
  output logic                  has_param_o,
  output logic [7:0]            row_index_o,
  output logic [7:0]            col_index_o,
  output logic [31:0]           word_bits_o,
  output logic                  checksum_ok_o,
  output logic                  last_o
);

  typedef enum logic [15:0] {
    PH_HUNT_A   = 16'h0001,
    PH_HUNT_Q   = 16'h0002,
    PH_TYPE     = 16'h0004,
    PH_C_COUNT  = 16'h0008,
    PH_C_CMD    = 16'h0010,
    PH_C_SEQ_LO = 16'h0020,
    PH_C_SEQ_HI = 16'h0040,
    PH_C_PAR_LO = 16'h0080,
    PH_C_PAR_HI = 16'h0100,
    PH_C_CHK_A  = 16'h0200,
    PH_C_CHK_B  = 16'h0400,
    PH_T_ROWS   = 16'h0800,
    PH_T_COLS   = 16'h1000,
    PH_T_WORD   = 16'h2000,
    PH_T_CHK_A  = 16'h4000,
    PH_T_CHK_B  = 16'h8000
  } phase_e;

  cfg_t cfg;

  frp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phase_e      phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]  count_q, count_d, cmd_q, cmd_d;
  logic [15:0] seq_q, seq_d, par_q, par_d;
  logic [7:0]  row_tot_q, row_tot_d, col_tot_q, col_tot_d;
  logic [7:0]  row_pos_q, row_pos_d, col_pos_q, col_pos_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [23:0] shift_q, shift_d;

  logic        in_accept;
  logic [7:0]  b;
  logic [7:0]  add_a, add_b;
  logic [7:0]  col_inc, row_inc;
  logic        has_par;
  logic        res_valid;
  result_t     res;

  // output register and skid stage
  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign b          = rx_byte_i;
  assign add_a      = sum_a_q + b;
  assign add_b      = sum_b_q + add_a;
  assign col_inc    = col_pos_q + 8'd1;
  assign row_inc    = row_pos_q + 8'd1;
  assign has_par    = count_q > PARAM_COUNT_MIN;

  // parser next state and result
  always_comb begin
    phase_d    = phase_q;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    count_d    = count_q;
    cmd_d      = cmd_q;
    seq_d      = seq_q;
    par_d      = par_q;
    row_tot_d  = row_tot_q;
    col_tot_d  = col_tot_q;
    row_pos_d  = row_pos_q;
    col_pos_d  = col_pos_q;
    byte_pos_d = byte_pos_q;
    shift_d    = shift_q;
    res_valid  = 1'b0;
    res        = '0;

    unique case (phase_q)
      PH_HUNT_A: begin
        phase_d = (b == SYNC_FIRST) ? PH_HUNT_Q : PH_HUNT_A;
      end
      PH_HUNT_Q: begin
        phase_d = (b == SYNC_SECOND) ? PH_TYPE : PH_HUNT_A;
      end
      PH_TYPE: begin
        sum_a_d = 8'd0;
        sum_b_d = 8'd0;
        priority if (b == TYPE_COMMAND) phase_d = PH_C_COUNT;
        else if (b == TYPE_TELEM)       phase_d = PH_T_ROWS;
        else                            phase_d = PH_HUNT_A;
      end
      PH_C_COUNT: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        count_d = b;
        phase_d = PH_C_CMD;
      end
      PH_C_CMD: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        cmd_d   = b;
        phase_d = PH_C_SEQ_LO;
      end
      PH_C_SEQ_LO: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        seq_d   = {seq_q[15:8], b};
        phase_d = PH_C_SEQ_HI;
      end
      PH_C_SEQ_HI: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        seq_d   = {b, seq_q[7:0]};
        phase_d = has_par ? PH_C_PAR_LO : PH_C_CHK_A;
      end
      PH_C_PAR_LO: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        par_d   = {par_q[15:8], b};
        phase_d = PH_C_PAR_HI;
      end
      PH_C_PAR_HI: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        par_d   = {b, par_q[7:0]};
        phase_d = PH_C_CHK_A;
      end
      PH_C_CHK_A: begin
        phase_d = (b == sum_a_q) ? PH_C_CHK_B : PH_HUNT_A;
      end
      PH_C_CHK_B: begin
        phase_d = PH_HUNT_A;
        if (b == sum_b_q) begin
          res_valid        = 1'b1;
          priority if (cmd_q == cfg.ack_code)      res.kind = KIND_ACK;
          else if (cmd_q == cfg.nack_code)         res.kind = KIND_NACK;
          else if (cmd_q == cfg.param_reply_code)  res.kind = KIND_PARAM;
          else                                     res.kind = KIND_UNKNOWN;
          res.command_code = cmd_q;
          res.sequence_id  = seq_q;
          res.param_id     = has_par ? par_q : 16'd0;
          res.has_param    = has_par;
          res.last         = 1'b1;
        end
      end
      PH_T_ROWS: begin
        sum_a_d   = add_a;
        sum_b_d   = add_b;
        row_tot_d = b;
        phase_d   = PH_T_COLS;
      end
      PH_T_COLS: begin
        sum_a_d    = add_a;
        sum_b_d    = add_b;
        col_tot_d  = b;
        row_pos_d  = 8'd0;
        col_pos_d  = 8'd0;
        byte_pos_d = 2'd0;
        shift_d    = 24'd0;
        phase_d    = (row_tot_q == 8'd0 || b == 8'd0) ? PH_T_CHK_A : PH_T_WORD;
      end
      PH_T_WORD: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        if (byte_pos_q != 2'd3) begin
          // gather low bytes of the word
          unique case (byte_pos_q)
            2'd0:    shift_d = {shift_q[23:8], b};
            2'd1:    shift_d = {shift_q[23:16], b, shift_q[7:0]};
            default: shift_d = {b, shift_q[15:0]};
          endcase
          byte_pos_d = byte_pos_q + 2'd1;
        end else begin
          res_valid     = 1'b1;
          res.kind      = KIND_TELEM_WORD;
          res.row_index = row_pos_q;
          res.col_index = col_pos_q;
          res.word_bits = {b, shift_q};
          byte_pos_d    = 2'd0;
          shift_d       = 24'd0;
          col_pos_d     = col_inc;
          // step to the next row at the end of a row
          if (col_inc == col_tot_q) begin
            col_pos_d = 8'd0;
            row_pos_d = row_inc;
            if (row_inc == row_tot_q) phase_d = PH_T_CHK_A;
          end
        end
      end
      PH_T_CHK_A: begin
        if (b != sum_a_q) begin
          phase_d   = PH_HUNT_A;
          res_valid = 1'b1;
          res.kind  = KIND_TELEM_END;
          res.last  = 1'b1;
        end else begin
          phase_d = PH_T_CHK_B;
        end
      end
      PH_T_CHK_B: begin
        phase_d         = PH_HUNT_A;
        res_valid       = 1'b1;
        res.kind        = KIND_TELEM_END;
        res.checksum_ok = (b == sum_b_q);
        res.last        = 1'b1;
      end
      default: begin
        phase_d = PH_HUNT_A;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT_A;
      sum_a_q    <= 8'd0;
      sum_b_q    <= 8'd0;
      count_q    <= 8'd0;
      cmd_q      <= 8'd0;
      seq_q      <= 16'd0;
      par_q      <= 16'd0;
      row_tot_q  <= 8'd0;
      col_tot_q  <= 8'd0;
      row_pos_q  <= 8'd0;
      col_pos_q  <= 8'd0;
      byte_pos_q <= 2'd0;
      shift_q    <= 24'd0;
    end else if (in_accept) begin
      phase_q    <= phase_d;
      sum_a_q    <= sum_a_d;
      sum_b_q    <= sum_b_d;
      count_q    <= count_d;
      cmd_q      <= cmd_d;
      seq_q      <= seq_d;
      par_q      <= par_d;
      row_tot_q  <= row_tot_d;
      col_tot_q  <= col_tot_d;
      row_pos_q  <= row_pos_d;
      col_pos_q  <= col_pos_d;
      byte_pos_q <= byte_pos_d;
      shift_q    <= shift_d;
    end
  end

  // output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (in_accept && res_valid) skid_valid_q <= 1'b1;
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_accept && res_valid;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (in_accept && res_valid) skid_q <= res;
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_accept && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign command_code_o = out_q.command_code;
  assign sequence_id_o  = out_q.sequence_id;
  assign param_id_o     = out_q.param_id;
  assign has_param_o    = out_q.has_param;
  assign row_index_o    = out_q.row_index;
  assign col_index_o    = out_q.col_index;
  assign word_bits_o    = out_q.word_bits;
  assign checksum_ok_o  = out_q.checksum_ok;
  assign last_o         = out_q.last;

endmodule
